// ===== sv/demand_paging_lru_memory_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the demand paging block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGING_LRU_MEMORY_TOP_ASSERT_SVH
`define DEMAND_PAGING_LRU_MEMORY_TOP_ASSERT_SVH

// same-cycle implication
`define DPL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpl assertion failed");

// next-cycle implication
`define DPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpl assertion failed");

`endif

// ===== sv/dpl_pkg.sv =====
// ----------------------------------------------------------------------------
// dpl_pkg
// Shared types and constants of the demand paging block.
// ----------------------------------------------------------------------------
package dpl_pkg;

  // default geometry (frame size must be a power of two)
  localparam int FRAME_BYTES_DEF       = 64;
  localparam int FRAME_COUNT_DEF       = 16;
  localparam int PROCESS_SLOTS_DEF     = 8;
  localparam int PAGES_PER_PROCESS_DEF = 16;

  // allocation limits
  localparam int MIN_ALLOC = 64;
  localparam int MAX_ALLOC = 65536;

  // occupancy threshold: busy * OV_DEN > count * OV_NUM
  localparam int OV_NUM = 19;
  localparam int OV_DEN = 20;

  localparam int CLK_W = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_PROC  = 3'd1,
    ST_VIOL     = 3'd2,
    ST_ALREADY  = 3'd3,
    ST_NO_MEM   = 3'd4,
    ST_BAD_SIZE = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_WB,
    S_EVICT,
    S_FILL,
    S_SETUP,
    S_OVCHK,
    S_OVSCAN,
    S_TOUCH,
    S_WR0,
    S_WR1,
    S_RD0,
    S_RD1,
    S_RD2,
    S_FREE,
    S_DONE
  } state_e;

endpackage

// ===== sv/dpl_byte_ram.sv =====
// ----------------------------------------------------------------------------
// dpl_byte_ram
// Single-port byte memory, registered read data.
// ----------------------------------------------------------------------------
module dpl_byte_ram #(
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== sv/dpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpl_ctrl
// Operation sequencer, process table and frame table; drives both byte RAMs.
// ----------------------------------------------------------------------------
module dpl_ctrl
  import dpl_pkg::*;
#(
  parameter int FRAME_BYTES       = FRAME_BYTES_DEF,
  parameter int FRAME_COUNT       = FRAME_COUNT_DEF,
  parameter int PROCESS_SLOTS     = PROCESS_SLOTS_DEF,
  parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF,
  parameter int FAW               = 10,
  parameter int BAW               = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     op_i,
  input  logic [2:0]     process_i,
  input  logic [15:0]    address_i,
  input  logic [15:0]    write_value_i,
  input  logic [16:0]    alloc_size_i,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic [15:0]    read_data_o,
  output logic           page_fault_o,
  output logic [4:0]     frames_used_o,
  // frame RAM
  output logic           fr_we_o,
  output logic [FAW-1:0] fr_addr_o,
  output logic [7:0]     fr_wdata_o,
  input  logic [7:0]     fr_rdata_i,
  // backing RAM
  output logic [BAW-1:0] bk_addr_o,
  input  logic [7:0]     bk_rdata_i,
  output logic           bk_we_o,
  output logic [7:0]     bk_wdata_o
);

  localparam int FBW   = $clog2(FRAME_BYTES);
  localparam int FCW   = $clog2(FRAME_COUNT);
  localparam int PW    = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
  localparam int PPW   = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int TOTAL = PROCESS_SLOTS * PAGES_PER_PROCESS;
  localparam int PGW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNTW  = $clog2(FRAME_COUNT + 1);
  localparam int KW    = FBW + 1;
  localparam int APW   = 16 - FBW;
  localparam int USEW  = $clog2(FRAME_COUNT * FRAME_BYTES + MAX_ALLOC + 1) + 1;
  localparam int OVW   = CNTW + 5;

  // ---------------- registers ----------------
  state_e                state_q, state_d;
  op_e                   op_q;
  logic [2:0]            p_q;
  logic [15:0]           addr_q;
  logic [15:0]           wval_q;
  logic [16:0]           size_q;
  status_e               status_q;
  logic [15:0]           rdata_q;
  logic                  fault_q;

  logic [PROCESS_SLOTS-1:0] pres_q;
  logic [16:0]              psize_q [PROCESS_SLOTS];
  logic [TOTAL-1:0]         bvalid_q;

  logic [FRAME_COUNT-1:0] fbusy_q;
  logic [FRAME_COUNT-1:0] fdirty_q;
  logic [PW-1:0]          fowner_q [FRAME_COUNT];
  logic [PPW-1:0]         fpage_q  [FRAME_COUNT];
  logic [CLK_W-1:0]       flu_q    [FRAME_COUNT];

  logic [CNTW-1:0]  cnt_q;
  logic [CLK_W-1:0] clk_q;

  logic [FCW-1:0]   scan_q;
  logic             free_found_q;
  logic [FCW-1:0]   free_idx_q;
  logic             have_q;
  logic [FCW-1:0]   lru_idx_q;
  logic [CLK_W-1:0] oldest_q;
  logic [FCW-1:0]   tgt_q;
  logic [FCW-1:0]   vic_q;
  logic             after_fill_q;
  logic [KW-1:0]    k_q;

  // ---------------- decode helpers ----------------
  logic            slot_ok, present, page_ok, viol, fits, hit, scan_last, ov;
  logic [PW-1:0]   p_idx;
  logic [APW-1:0]  page_full;
  logic [PPW-1:0]  page_idx;
  logic [FBW-1:0]  off, off_nx, k_lo, k_prev;
  logic [PGW-1:0]  pg_cur, vic_pg;
  logic [FCW-1:0]  hit_idx;
  logic [USEW-1:0] used_sum;
  logic            k_end;
  logic [FCW-1:0]  last_frame;

  assign last_frame = FCW'(FRAME_COUNT - 1);
  assign p_idx     = PW'(p_q);
  assign slot_ok   = (32'(p_q) < PROCESS_SLOTS);
  assign present   = slot_ok && pres_q[p_idx];
  assign page_full = addr_q[15:FBW];
  assign page_idx  = PPW'(page_full);
  assign page_ok   = (32'(page_full) < PAGES_PER_PROCESS);
  assign off       = addr_q[FBW-1:0];
  assign off_nx    = off + FBW'(1);
  assign viol      = (17'(addr_q) >= psize_q[p_idx]) || !page_ok;
  assign fits      = (off != FBW'(FRAME_BYTES - 1));
  assign pg_cur    = PGW'(32'(p_idx) * PAGES_PER_PROCESS + 32'(page_idx));
  assign vic_pg    = PGW'(32'(fowner_q[vic_q]) * PAGES_PER_PROCESS + 32'(fpage_q[vic_q]));
  assign used_sum  = USEW'(cnt_q) * USEW'(FRAME_BYTES) + USEW'(size_q);
  assign ov        = (OVW'(cnt_q) * OVW'(OV_DEN)) > OVW'(FRAME_COUNT * OV_NUM);
  assign scan_last = (scan_q == last_frame);
  assign k_lo      = k_q[FBW-1:0];
  assign k_prev    = k_lo - FBW'(1);
  assign k_end     = (k_q == KW'(FRAME_BYTES));

  // resident lookup: compare every frame tag
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (fbusy_q[i] && fowner_q[i] == p_idx && fpage_q[i] == page_idx) begin
        hit     = 1'b1;
        hit_idx = FCW'(i);
      end
    end
  end

  // ---------------- next state and RAM ports ----------------
  always_comb begin
    state_d    = state_q;
    fr_we_o    = 1'b0;
    fr_addr_o  = {tgt_q, off};
    fr_wdata_o = wval_q[7:0];
    bk_we_o    = 1'b0;
    bk_addr_o  = {pg_cur, k_lo};
    bk_wdata_o = fr_rdata_i;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_DONE;
        if (slot_ok) begin
          unique case (op_q)
            OP_ALLOC: state_d = S_DONE;
            OP_FREE: begin
              if (present) state_d = S_FREE;
            end
            OP_READ, OP_WRITE: begin
              if (present && !viol) state_d = hit ? S_TOUCH : S_SCAN;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) state_d = S_PICK;
      end
      S_PICK: begin
        if (free_found_q)               state_d = S_FILL;
        else if (fdirty_q[lru_idx_q])   state_d = S_WB;
        else                            state_d = S_EVICT;
      end
      S_WB: begin
        // read frame byte k, write backing byte k-1
        fr_addr_o  = {vic_q, k_lo};
        bk_addr_o  = {vic_pg, k_prev};
        bk_we_o    = (k_q != '0);
        bk_wdata_o = fr_rdata_i;
        if (k_end) state_d = S_EVICT;
      end
      S_EVICT: begin
        state_d = after_fill_q ? S_TOUCH : S_FILL;
      end
      S_FILL: begin
        // read backing byte k, write frame byte k-1
        bk_addr_o  = {pg_cur, k_lo};
        fr_addr_o  = {tgt_q, k_prev};
        fr_we_o    = (k_q != '0);
        fr_wdata_o = bvalid_q[pg_cur] ? bk_rdata_i : 8'h00;
        if (k_end) state_d = S_SETUP;
      end
      S_SETUP: state_d = S_OVCHK;
      S_OVCHK: state_d = ov ? S_OVSCAN : S_TOUCH;
      S_OVSCAN: begin
        if (scan_q != tgt_q && fbusy_q[scan_q] && fowner_q[scan_q] != p_idx) begin
          state_d = fdirty_q[scan_q] ? S_WB : S_EVICT;
        end else if (scan_last) begin
          state_d = S_TOUCH;
        end
      end
      S_TOUCH: begin
        if (!fits)                 state_d = S_DONE;
        else if (op_q == OP_WRITE) state_d = S_WR0;
        else                       state_d = S_RD0;
      end
      S_WR0: begin
        fr_we_o    = 1'b1;
        fr_addr_o  = {tgt_q, off};
        fr_wdata_o = wval_q[7:0];
        state_d    = S_WR1;
      end
      S_WR1: begin
        fr_we_o    = 1'b1;
        fr_addr_o  = {tgt_q, off_nx};
        fr_wdata_o = wval_q[15:8];
        state_d    = S_DONE;
      end
      S_RD0: begin
        fr_addr_o = {tgt_q, off};
        state_d   = S_RD1;
      end
      S_RD1: begin
        fr_addr_o = {tgt_q, off_nx};
        state_d   = S_RD2;
      end
      S_RD2: state_d = S_DONE;
      S_FREE: begin
        if (scan_last) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- tables and counters ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q   <= '0;
      bvalid_q <= '0;
      fbusy_q  <= '0;
      fdirty_q <= '0;
      cnt_q    <= '0;
      clk_q    <= '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        fowner_q[i] <= '0;
        fpage_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        S_DECODE: begin
          if (slot_ok && op_q == OP_ALLOC && !pres_q[p_idx] &&
              used_sum <= USEW'(FRAME_COUNT * FRAME_BYTES) &&
              size_q >= 17'(MIN_ALLOC) && size_q <= 17'(MAX_ALLOC) &&
              (size_q & (size_q - 17'd1)) == 17'd0) begin
            pres_q[p_idx] <= 1'b1;
            // backing pages read as zero until written back
            for (int k = 0; k < PAGES_PER_PROCESS; k++) begin
              bvalid_q[PGW'(32'(p_idx) * PAGES_PER_PROCESS + k)] <= 1'b0;
            end
          end
          if (slot_ok && op_q == OP_FREE && pres_q[p_idx]) pres_q[p_idx] <= 1'b0;
        end
        S_WB: begin
          if (k_end) bvalid_q[vic_pg] <= 1'b1;
        end
        S_EVICT: begin
          fbusy_q[vic_q]  <= 1'b0;
          fdirty_q[vic_q] <= 1'b0;
          fowner_q[vic_q] <= '0;
          fpage_q[vic_q]  <= '0;
          cnt_q           <= cnt_q - CNTW'(1);
        end
        S_SETUP: begin
          fbusy_q[tgt_q]  <= 1'b1;
          fdirty_q[tgt_q] <= 1'b0;
          fowner_q[tgt_q] <= p_idx;
          fpage_q[tgt_q]  <= page_idx;
          cnt_q           <= cnt_q + CNTW'(1);
          clk_q           <= clk_q + 1'b1;
        end
        S_TOUCH: begin
          clk_q <= clk_q + 1'b1;
          if (op_q == OP_WRITE) fdirty_q[tgt_q] <= 1'b1;
        end
        S_FREE: begin
          if (fbusy_q[scan_q] && fowner_q[scan_q] == p_idx) begin
            fbusy_q[scan_q]  <= 1'b0;
            fowner_q[scan_q] <= '0;
            fpage_q[scan_q]  <= '0;
            cnt_q            <= cnt_q - CNTW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- payload and scan registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_q   <= op_e'(op_i);
          p_q    <= process_i;
          addr_q <= address_i;
          wval_q <= write_value_i;
          size_q <= alloc_size_i;
        end
      end
      S_DECODE: begin
        status_q     <= ST_OK;
        rdata_q      <= '0;
        fault_q      <= 1'b0;
        scan_q       <= '0;
        free_found_q <= 1'b0;
        have_q       <= 1'b0;
        tgt_q        <= hit_idx;
        if (!slot_ok) begin
          status_q <= ST_NO_PROC;
        end else begin
          unique case (op_q)
            OP_ALLOC: begin
              priority if (pres_q[p_idx])
                status_q <= ST_ALREADY;
              else if (used_sum > USEW'(FRAME_COUNT * FRAME_BYTES))
                status_q <= ST_NO_MEM;
              else if (size_q < 17'(MIN_ALLOC) || size_q > 17'(MAX_ALLOC))
                status_q <= ST_BAD_SIZE;
              else if ((size_q & (size_q - 17'd1)) != 17'd0)
                status_q <= ST_BAD_SIZE;
              else
                psize_q[p_idx] <= size_q;
            end
            OP_FREE: begin
              if (!pres_q[p_idx]) status_q <= ST_NO_PROC;
            end
            OP_READ, OP_WRITE: begin
              priority if (!pres_q[p_idx]) status_q <= ST_NO_PROC;
              else if (viol)               status_q <= ST_VIOL;
              else if (!hit)               fault_q  <= 1'b1;
              else                         ;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // first free frame and least recently used busy frame
        if (!fbusy_q[scan_q] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= scan_q;
        end
        if (fbusy_q[scan_q] && (!have_q || flu_q[scan_q] < oldest_q)) begin
          have_q    <= 1'b1;
          oldest_q  <= flu_q[scan_q];
          lru_idx_q <= scan_q;
        end
        scan_q <= scan_q + FCW'(1);
      end
      S_PICK: begin
        k_q          <= '0;
        after_fill_q <= 1'b0;
        tgt_q        <= free_found_q ? free_idx_q : lru_idx_q;
        vic_q        <= lru_idx_q;
      end
      S_WB, S_FILL: begin
        k_q <= k_q + KW'(1);
      end
      S_EVICT: begin
        k_q <= '0;
      end
      S_SETUP: begin
        flu_q[tgt_q] <= clk_q + 1'b1;
      end
      S_OVCHK: begin
        scan_q <= '0;
      end
      S_OVSCAN: begin
        after_fill_q <= 1'b1;
        vic_q        <= scan_q;
        k_q          <= '0;
        scan_q       <= scan_q + FCW'(1);
      end
      S_TOUCH: begin
        flu_q[tgt_q] <= clk_q + 1'b1;
      end
      S_RD1: rdata_q[7:0]  <= fr_rdata_i;
      S_RD2: rdata_q[15:8] <= fr_rdata_i;
      S_FREE: scan_q <= scan_q + FCW'(1);
      default: ;
    endcase
  end

  // ---------------- outputs ----------------
  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign read_data_o   = rdata_q;
  assign page_fault_o  = fault_q;
  assign frames_used_o = 5'(cnt_q);

endmodule

// ===== sv/demand_paging_lru_memory_top.sv =====
// ----------------------------------------------------------------------------
// demand_paging_lru_memory_top
// Demand-paged per-process memory with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One operation is taken while busy is low and start is high; its single
// result appears for exactly one cycle with done_o high and cannot be held
// off. Allocate, deallocate of an absent slot and every error finish right
// after decode. Deallocate walks the frame table. A resident read or write
// stamps the frame for LRU and then accesses the frame RAM. A page fault
// adds a frame scan, a victim pick, a page load through the single byte port
// of each RAM, a table update and an occupancy check. Taking a frame away
// from another page adds an eviction step, preceded by a write-back when
// that page is dirty. Under high occupancy a second frame walk follows, then
// at most one more such eviction. Frame size must be a power of two. No
// clearing pass follows reset.
`include "demand_paging_lru_memory_top_assert.svh"

module demand_paging_lru_memory_top
  import dpl_pkg::*;
#(
  parameter int FRAME_BYTES       = FRAME_BYTES_DEF,
  parameter int FRAME_COUNT       = FRAME_COUNT_DEF,
  parameter int PROCESS_SLOTS     = PROCESS_SLOTS_DEF,
  parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [2:0]  process_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_value_i,
  input  logic [16:0] alloc_size_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] read_data_o,
  output logic        page_fault_o,
  output logic [4:0]  frames_used_o
);

  localparam int FBW   = $clog2(FRAME_BYTES);
  localparam int FCW   = $clog2(FRAME_COUNT);
  localparam int TOTAL = PROCESS_SLOTS * PAGES_PER_PROCESS;
  localparam int PGW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int FAW   = FCW + FBW;
  localparam int BAW   = PGW + FBW;

  logic           fr_we;
  logic [FAW-1:0] fr_addr;
  logic [7:0]     fr_wdata, fr_rdata;
  logic           bk_we;
  logic [BAW-1:0] bk_addr;
  logic [7:0]     bk_wdata, bk_rdata;

  dpl_ctrl #(
    .FRAME_BYTES      (FRAME_BYTES),
    .FRAME_COUNT      (FRAME_COUNT),
    .PROCESS_SLOTS    (PROCESS_SLOTS),
    .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
    .FAW              (FAW),
    .BAW              (BAW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .process_i    (process_i),
    .address_i    (address_i),
    .write_value_i(write_value_i),
    .alloc_size_i (alloc_size_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .page_fault_o (page_fault_o),
    .frames_used_o(frames_used_o),
    .fr_we_o      (fr_we),
    .fr_addr_o    (fr_addr),
    .fr_wdata_o   (fr_wdata),
    .fr_rdata_i   (fr_rdata),
    .bk_addr_o    (bk_addr),
    .bk_rdata_i   (bk_rdata),
    .bk_we_o      (bk_we),
    .bk_wdata_o   (bk_wdata)
  );

  // resident frame bytes
  dpl_byte_ram #(.AW(FAW)) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (fr_we),
    .addr_i (fr_addr),
    .wdata_i(fr_wdata),
    .rdata_o(fr_rdata)
  );

  // backing copy of every process page
  dpl_byte_ram #(.AW(BAW)) u_backing_ram (
    .clk_i  (clk_i),
    .we_i   (bk_we),
    .addr_i (bk_addr),
    .wdata_i(bk_wdata),
    .rdata_o(bk_rdata)
  );

  // ---------------- assertions ----------------
  `DPL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DPL_ASSERT_NEXT(a_done_idle, done_o, !busy && !done_o)
  `DPL_ASSERT_NOW(a_fault_ok, done_o && page_fault_o, status_o == ST_OK)
  `DPL_ASSERT_NOW(a_frames_range, done_o, 32'(frames_used_o) <= FRAME_COUNT)

endmodule
